[rtl/chacha_pkg.sv]
// Shared types and constants for the ChaCha stream cipher core.
package chacha_pkg;

    localparam int unsigned WordW = 32;
    localparam int unsigned BlockBytes = 64;
    localparam int unsigned PosW = 7;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = 64;
    localparam int unsigned RoundW = 7;

    localparam logic [CfgIdxW-1:0] RegKey0 = 3'd0;
    localparam logic [CfgIdxW-1:0] RegKey1 = 3'd1;
    localparam logic [CfgIdxW-1:0] RegKey2 = 3'd2;
    localparam logic [CfgIdxW-1:0] RegKey3 = 3'd3;
    localparam logic [CfgIdxW-1:0] RegLongKey = 3'd4;
    localparam logic [CfgIdxW-1:0] RegNonce = 3'd5;
    localparam logic [CfgIdxW-1:0] RegCounter = 3'd6;
    localparam logic [CfgIdxW-1:0] RegRounds = 3'd7;

    localparam logic [WordW-1:0] Sigma0 = 32'h61707865;
    localparam logic [WordW-1:0] Sigma1 = 32'h3320646e;
    localparam logic [WordW-1:0] Sigma2 = 32'h79622d32;
    localparam logic [WordW-1:0] Sigma3 = 32'h6b206574;
    localparam logic [WordW-1:0] Tau1 = 32'h3120646e;
    localparam logic [WordW-1:0] Tau2 = 32'h79622d36;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;      // build the input state
        logic qr;        // run one quarter round
        logic finish;    // add input state back, bump counter
    } chacha_cmd_t;

    // Word indexes a, b, c, d of quarter round k (0..7).
    function automatic logic [15:0] qr_idx(input logic [2:0] k);
        logic [15:0] r;
        unique case (k)
            3'd0: r = {4'd12, 4'd8, 4'd4, 4'd0};
            3'd1: r = {4'd13, 4'd9, 4'd5, 4'd1};
            3'd2: r = {4'd14, 4'd10, 4'd6, 4'd2};
            3'd3: r = {4'd15, 4'd11, 4'd7, 4'd3};
            3'd4: r = {4'd15, 4'd10, 4'd5, 4'd0};
            3'd5: r = {4'd12, 4'd11, 4'd6, 4'd1};
            3'd6: r = {4'd13, 4'd8, 4'd7, 4'd2};
            default: r = {4'd14, 4'd9, 4'd4, 4'd3};
        endcase
        return r;
    endfunction

endpackage

[rtl/chacha_dp.sv]
// Datapath: state words, shared quarter-round unit and keystream block.
module chacha_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  chacha_pkg::chacha_cmd_t           cmd,
    input  logic [2:0]                        qr_sel,
    input  logic                              reload,
    input  logic [4*chacha_pkg::CfgDataW-1:0] key,
    input  logic                              long_key,
    input  logic [chacha_pkg::CfgDataW-1:0]   nonce,
    input  logic [chacha_pkg::CfgDataW-1:0]   start_ctr,
    input  logic [5:0]                        byte_sel,
    output logic [7:0]                        ks_byte
);

    logic [chacha_pkg::WordW-1:0] w_reg [16];
    logic [chacha_pkg::WordW-1:0] s_reg [16];
    logic [127:0] ctr_reg;
    logic [chacha_pkg::WordW-1:0] init [16];
    logic [15:0] idx;
    logic [31:0] a0, b0, c0, d0, a1, b1, c1, d1, a2, d2, c2, b2;

    always_comb
    begin
        init[0] = chacha_pkg::Sigma0;
        init[1] = long_key ? chacha_pkg::Sigma1 : chacha_pkg::Tau1;
        init[2] = long_key ? chacha_pkg::Sigma2 : chacha_pkg::Tau2;
        init[3] = chacha_pkg::Sigma3;
        for (int i = 0; i < 4; i++)
        begin
            init[4+i] = key[32*i +: 32];
            init[8+i] = long_key ? key[128 + 32*i +: 32] : key[32*i +: 32];
            init[12+i] = ctr_reg[32*i +: 32];
        end
    end

    // One quarter round per cycle.
    assign idx = chacha_pkg::qr_idx(qr_sel);
    always_comb
    begin
        a0 = w_reg[idx[3:0]] + w_reg[idx[7:4]];
        d0 = w_reg[idx[15:12]] ^ a0;
        d0 = {d0[15:0], d0[31:16]};
        c0 = w_reg[idx[11:8]] + d0;
        b0 = w_reg[idx[7:4]] ^ c0;
        b0 = {b0[19:0], b0[31:20]};
        a1 = a0 + b0;
        d1 = d0 ^ a1;
        d1 = {d1[23:0], d1[31:24]};
        c1 = c0 + d1;
        b1 = b0 ^ c1;
        b1 = {b1[24:0], b1[31:25]};
        a2 = a1; b2 = b1; c2 = c1; d2 = d1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctr_reg <= '0;
        end
        else if (reload)
        begin
            ctr_reg <= {nonce, start_ctr};
        end
        else if (cmd.finish)
        begin
            ctr_reg <= ctr_reg + 128'd1;
        end
    end

    // After the finish step the working words hold the keystream block.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            w_reg <= init;
            s_reg <= init;
        end
        else if (cmd.qr)
        begin
            w_reg[idx[3:0]] <= a2;
            w_reg[idx[7:4]] <= b2;
            w_reg[idx[11:8]] <= c2;
            w_reg[idx[15:12]] <= d2;
        end
        else if (cmd.finish)
        begin
            for (int i = 0; i < 16; i++)
            begin
                w_reg[i] <= w_reg[i] + s_reg[i];
            end
        end
    end

    assign ks_byte = w_reg[byte_sel[5:2]][8*byte_sel[1:0] +: 8];

endmodule

[rtl/chacha_ctrl.sv]
// Controller: block sequencing, byte position and stream handshake.
module chacha_ctrl (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   reload,
    input  logic [chacha_pkg::RoundW-1:0]          rounds,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [7:0]                             in_byte,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [7:0]                             out_byte,
    input  logic [7:0]                             ks_byte,
    output logic [5:0]                             byte_sel,
    output chacha_pkg::chacha_cmd_t                cmd,
    output logic [2:0]                             qr_sel
);

    typedef enum logic [1:0] {IDLE, LOAD, ROUND, FINISH} state_t;

    state_t state_reg;
    logic [chacha_pkg::PosW-1:0] pos_reg;
    logic [2:0] qr_reg;
    logic [chacha_pkg::RoundW-1:0] dr_reg;
    logic out_valid_reg;
    logic [7:0] out_byte_reg;
    logic take;
    logic have_ks;

    assign have_ks = !pos_reg[chacha_pkg::PosW-1];
    assign in_ready = (state_reg == IDLE) && have_ks && !reload
                      && (!out_valid_reg || out_ready);
    assign take = in_valid && in_ready;
    assign byte_sel = pos_reg[5:0];
    assign out_valid = out_valid_reg;
    assign out_byte = out_byte_reg;
    assign qr_sel = qr_reg;
    assign cmd.load = (state_reg == LOAD);
    assign cmd.qr = (state_reg == ROUND);
    assign cmd.finish = (state_reg == FINISH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            pos_reg <= 7'(chacha_pkg::BlockBytes);
            qr_reg <= '0;
            dr_reg <= '0;
            out_valid_reg <= 1'b0;
            out_byte_reg <= '0;
        end
        else
        begin
            if (take)
            begin
                out_valid_reg <= 1'b1;
                out_byte_reg <= in_byte ^ ks_byte;
                pos_reg <= pos_reg + 7'd1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (reload)
            begin
                state_reg <= IDLE;
                pos_reg <= 7'(chacha_pkg::BlockBytes);
            end
            else
            begin
                unique case (state_reg)
                    IDLE:
                    begin
                        if (!have_ks && in_valid)
                        begin
                            state_reg <= LOAD;
                        end
                    end
                    LOAD:
                    begin
                        qr_reg <= '0;
                        dr_reg <= '0;
                        state_reg <= (rounds == '0) ? FINISH : ROUND;
                    end
                    ROUND:
                    begin
                        qr_reg <= qr_reg + 3'd1;
                        if (qr_reg == 3'd7)
                        begin
                            dr_reg <= dr_reg + 7'd1;
                            if (dr_reg + 7'd1 == rounds)
                            begin
                                state_reg <= FINISH;
                            end
                        end
                    end
                    FINISH:
                    begin
                        pos_reg <= '0;
                        state_reg <= IDLE;
                    end
                    default: state_reg <= IDLE;
                endcase
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        take |-> (state_reg == IDLE) && !pos_reg[6])
        else $error("byte taken without keystream");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FINISH) && !reload |=> pos_reg == '0)
        else $error("position not cleared after block");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg)
        else $error("result lost");

endmodule

[rtl/chacha_stream_cipher_core.sv]
// Top level of the ChaCha stream cipher core.
// A byte with keystream ready is answered from a register in the cycle after acceptance.
// A new 64-byte block runs a load step, eight quarter rounds per double round
// on the one shared quarter-round unit, then a finish step; no byte is taken
// while a block is being computed.
// Reset (rst_n, asynchronous) restores register defaults and forces a new block.
module chacha_stream_cipher_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Configuration write port.
    input  logic                                 cfg_we,
    input  logic [chacha_pkg::CfgIdxW-1:0]       cfg_index,
    input  logic [chacha_pkg::CfgDataW-1:0]      cfg_data,
    // Input beats.
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [7:0]                           s_tdata,   // [7:0] data_byte
    // Output beats.
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [7:0]                           m_tdata    // [7:0] out_byte
);

    logic [4*chacha_pkg::CfgDataW-1:0] key_reg;
    logic long_key_reg;
    logic [chacha_pkg::CfgDataW-1:0] nonce_reg;
    logic [chacha_pkg::CfgDataW-1:0] ctr_start_reg;
    logic [chacha_pkg::RoundW-1:0] rounds_reg;
    logic reload_reg;
    chacha_pkg::chacha_cmd_t cmd;
    logic [2:0] qr_sel;
    logic [5:0] byte_sel;
    logic [7:0] ks_byte;

    // Every write lands in a register; reload_reg then reloads the counter
    // and discards the current block on the following cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
            long_key_reg <= 1'b1;
            nonce_reg <= '0;
            ctr_start_reg <= '0;
            rounds_reg <= 7'd10;
            reload_reg <= 1'b1;
        end
        else
        begin
            reload_reg <= cfg_we;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    chacha_pkg::RegKey0: key_reg[63:0] <= cfg_data;
                    chacha_pkg::RegKey1: key_reg[127:64] <= cfg_data;
                    chacha_pkg::RegKey2: key_reg[191:128] <= cfg_data;
                    chacha_pkg::RegKey3: key_reg[255:192] <= cfg_data;
                    chacha_pkg::RegLongKey: long_key_reg <= cfg_data[0];
                    chacha_pkg::RegNonce: nonce_reg <= cfg_data;
                    chacha_pkg::RegCounter: ctr_start_reg <= cfg_data;
                    chacha_pkg::RegRounds: rounds_reg <= cfg_data[6:0];
                    default: rounds_reg <= rounds_reg;
                endcase
            end
        end
    end

    chacha_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .reload(reload_reg), .rounds(rounds_reg),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_byte(s_tdata),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_byte(m_tdata),
        .ks_byte(ks_byte), .byte_sel(byte_sel), .cmd(cmd), .qr_sel(qr_sel)
    );

    chacha_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .qr_sel(qr_sel),
        .reload(reload_reg), .key(key_reg), .long_key(long_key_reg),
        .nonce(nonce_reg), .start_ctr(ctr_start_reg), .byte_sel(byte_sel),
        .ks_byte(ks_byte)
    );

endmodule

[tb/tb.sv]
// Self-checking testbench for the ChaCha stream cipher core.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CycleLimit = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [chacha_pkg::CfgIdxW-1:0] cfg_index = chacha_pkg::RegKey0;
    logic [chacha_pkg::CfgDataW-1:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [7:0] s_tdata = '0;   // [7:0] data_byte
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [7:0] m_tdata;        // [7:0] out_byte

    chacha_stream_cipher_core dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #10 clk = ~clk;

    // Shadow copy of the configuration registers.
    logic [63:0] key_reg [4];
    logic        long_key;
    logic [63:0] nonce_reg;
    logic [63:0] counter_reg;
    logic [6:0]  rounds_reg;

    // Keystream generator state: the 128-bit block counter (words 12..15),
    // the current block and the next byte position within it.
    logic [63:0] blk_ctr_lo;
    logic [63:0] blk_ctr_hi;
    logic [7:0]  ks_bytes [64];
    int unsigned ks_pos;
    logic [31:0] mix [16];

    logic [7:0] pending_bytes [$];
    logic [7:0] cipher_expected [$];

    int errors = 0;
    int unsigned cycles = 0;
    bit in_taken = 1'b0;
    bit out_taken = 1'b0;
    bit hold_src = 1'b0;
    bit calm = 1'b0;
    int unsigned src_wait = 0;
    int unsigned snk_wait = 0;

    function automatic logic [31:0] rotl(logic [31:0] v, int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic void quarter(int a, int b, int c, int d);
        mix[a] += mix[b]; mix[d] = rotl(mix[d] ^ mix[a], 16);
        mix[c] += mix[d]; mix[b] = rotl(mix[b] ^ mix[c], 12);
        mix[a] += mix[b]; mix[d] = rotl(mix[d] ^ mix[a], 8);
        mix[c] += mix[d]; mix[b] = rotl(mix[b] ^ mix[c], 7);
    endfunction

    // Builds the next 64-byte keystream block and bumps the 128-bit counter.
    function automatic void make_keystream_block();
        logic [31:0] init [16];
        logic [63:0] hi2;
        logic [63:0] hi3;
        logic [31:0] v;
        init[0] = chacha_pkg::Sigma0;
        init[3] = chacha_pkg::Sigma3;
        if (long_key)
        begin
            init[1] = chacha_pkg::Sigma1; init[2] = chacha_pkg::Sigma2;
            hi2 = key_reg[2]; hi3 = key_reg[3];
        end
        else
        begin
            // Short key: the 16-byte key is repeated with the tau constant.
            init[1] = chacha_pkg::Tau1; init[2] = chacha_pkg::Tau2;
            hi2 = key_reg[0]; hi3 = key_reg[1];
        end
        {init[5], init[4]} = key_reg[0];
        {init[7], init[6]} = key_reg[1];
        {init[9], init[8]} = hi2;
        {init[11], init[10]} = hi3;
        {init[13], init[12]} = blk_ctr_lo;
        {init[15], init[14]} = blk_ctr_hi;
        mix = init;
        for (int r = 0; r < rounds_reg; r++)
        begin
            quarter(0, 4, 8, 12); quarter(1, 5, 9, 13);
            quarter(2, 6, 10, 14); quarter(3, 7, 11, 15);
            quarter(0, 5, 10, 15); quarter(1, 6, 11, 12);
            quarter(2, 7, 8, 13); quarter(3, 4, 9, 14);
        end
        for (int i = 0; i < 16; i++)
        begin
            v = mix[i] + init[i];
            for (int j = 0; j < 4; j++)
                ks_bytes[4 * i + j] = v[8 * j +: 8];
        end
        {blk_ctr_hi, blk_ctr_lo} = {blk_ctr_hi, blk_ctr_lo} + 128'd1;
        ks_pos = 0;
    endfunction

    function automatic logic [7:0] next_keystream_byte();
        if (ks_pos >= chacha_pkg::BlockBytes)
            make_keystream_block();
        ks_pos++;
        return ks_bytes[ks_pos - 1];
    endfunction

    // Every register write reloads the counter and forces a fresh block.
    function automatic void shadow_write(logic [chacha_pkg::CfgIdxW-1:0] idx,
                                         logic [63:0] val);
        case (idx)
            chacha_pkg::RegKey0:    key_reg[0] = val;
            chacha_pkg::RegKey1:    key_reg[1] = val;
            chacha_pkg::RegKey2:    key_reg[2] = val;
            chacha_pkg::RegKey3:    key_reg[3] = val;
            chacha_pkg::RegLongKey: long_key = val[0];
            chacha_pkg::RegNonce:   nonce_reg = val;
            chacha_pkg::RegCounter: counter_reg = val;
            chacha_pkg::RegRounds:  rounds_reg = val[6:0];
            default:    ;
        endcase
        blk_ctr_lo = counter_reg;
        blk_ctr_hi = nonce_reg;
        ks_pos = chacha_pkg::BlockBytes;
    endfunction

    function automatic void shadow_reset();
        key_reg = '{default: 64'd0};
        long_key = 1'b1;
        nonce_reg = '0;
        counter_reg = '0;
        rounds_reg = 7'd10;
        blk_ctr_lo = '0;
        blk_ctr_hi = '0;
        ks_pos = chacha_pkg::BlockBytes;
    endfunction

    task automatic report_mismatch(string what, logic [7:0] want, logic [7:0] got);
        $display("MISMATCH %s: expected %02h, got %02h at cycle %0d", what, want, got, cycles);
        errors++;
    endtask

    task automatic write_reg(logic [chacha_pkg::CfgIdxW-1:0] idx, logic [63:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        shadow_write(idx, val);
    endtask

    // Waits until the core has drained: no byte left to send or to check.
    task automatic wait_drained();
        while (pending_bytes.size() != 0 || s_tvalid || cipher_expected.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [63:0] pick_word64();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return 64'h0000_0000_FFFF_FFFF;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    function automatic logic [6:0] pick_rounds();
        case ($urandom_range(0, 15))
            0: return 7'd0;
            1: return 7'd1;
            2: return 7'd127;
            3, 4, 5: return 7'd10;
            6: return 7'd4;
            default: return 7'($urandom_range(0, 24));
        endcase
    endfunction

    task automatic write_random_reg(logic [chacha_pkg::CfgIdxW-1:0] idx);
        case (idx)
            chacha_pkg::RegLongKey: write_reg(idx, 64'($urandom_range(0, 1)));
            chacha_pkg::RegRounds:  write_reg(idx, 64'(pick_rounds()));
            chacha_pkg::RegKey0, chacha_pkg::RegKey1,
            chacha_pkg::RegKey2, chacha_pkg::RegKey3:
                write_reg(idx, {$urandom(), $urandom()});
            default:    write_reg(idx, pick_word64());
        endcase
    endtask

    // Cycle counter and timeout.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CycleLimit)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Monitor: checks output beats against the oldest prediction and predicts
    // the ciphertext for every accepted input beat.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                out_taken = 1'b1;
                if (cipher_expected.size() == 0)
                    report_mismatch("unexpected beat", 8'h00, m_tdata);
                else if (m_tdata !== cipher_expected[0])
                    report_mismatch("out_byte", cipher_expected.pop_front(), m_tdata);
                else
                    void'(cipher_expected.pop_front());
            end
            if (s_tvalid && s_tready)
            begin
                in_taken = 1'b1;
                cipher_expected.push_back(s_tdata ^ next_keystream_byte());
            end
        end
    end

    // Driver: presents queued bytes with a random gap before each one.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_taken)
            begin
                in_taken = 1'b0;
                src_wait = calm ? 0 : $urandom_range(0, 9);
                if (src_wait == 0 && !hold_src && pending_bytes.size() != 0)
                begin
                    s_tdata <= pending_bytes.pop_front();
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
            else if (!s_tvalid)
            begin
                if (src_wait > 0)
                    src_wait--;
                else if (!hold_src && pending_bytes.size() != 0)
                begin
                    s_tdata <= pending_bytes.pop_front();
                    s_tvalid <= 1'b1;
                end
            end
        end
    end

    // Receiver: stalls a random number of cycles before each output beat.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_taken)
            begin
                out_taken = 1'b0;
                snk_wait = calm ? 0 : $urandom_range(0, 9);
            end
            if (snk_wait > 0)
            begin
                snk_wait--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        int sent;
        int n;
        shadow_reset();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset defaults, data extremes and single-bit patterns.
        pending_bytes = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h55, 8'hAA, 8'h7F, 8'hFE};
        wait_drained();
        // Zero double rounds: the keystream is the input state doubled.
        write_reg(chacha_pkg::RegRounds, 64'd0);
        pending_bytes = '{8'h00, 8'h00, 8'hFF, 8'h3C, 8'hC3, 8'h00};
        wait_drained();
        // Short key with tau, then all registers to their extremes.
        write_reg(chacha_pkg::RegKey0, 64'h0706050403020100);
        write_reg(chacha_pkg::RegKey1, 64'h0F0E0D0C0B0A0908);
        write_reg(chacha_pkg::RegLongKey, 64'd0);
        write_reg(chacha_pkg::RegRounds, 64'd10);
        pending_bytes = '{8'h00, 8'h11, 8'h22, 8'h33, 8'hFF};
        wait_drained();
        for (int r = chacha_pkg::RegKey0; r <= chacha_pkg::RegCounter; r++)
            write_reg(r[chacha_pkg::CfgIdxW-1:0], '1);
        write_reg(chacha_pkg::RegRounds, 64'd127);
        pending_bytes = '{8'h00, 8'hFF, 8'h5A, 8'hA5};
        wait_drained();

        // Random phases. The first one writes every register; the rest write a
        // random subset. Long phases cross block and counter boundaries.
        sent = 23;
        for (int ph = 0; sent < 1250; ph++)
        begin
            for (int r = chacha_pkg::RegKey0; r <= chacha_pkg::RegRounds; r++)
                if (ph == 0 || $urandom_range(0, 2) == 0)
                    write_random_reg(r[chacha_pkg::CfgIdxW-1:0]);
            if ($urandom_range(0, 5) == 0)
                write_reg(chacha_pkg::RegCounter, '1);
            calm = ($urandom_range(0, 4) == 0);
            n = (rounds_reg > 40) ? $urandom_range(10, 70) : $urandom_range(20, 200);
            for (int i = 0; i < n; i++)
                pending_bytes.push_back(8'($urandom()));
            sent += n;
            if (ph == 2)
            begin
                // Hold the sender mid-phase until every result is back.
                while (pending_bytes.size() > n / 2)
                    @(posedge clk);
                hold_src = 1'b1;
                while (s_tvalid || cipher_expected.size() != 0)
                    @(posedge clk);
                hold_src = 1'b0;
            end
            wait_drained();
        end

        repeat (20) @(posedge clk);
        while (cipher_expected.size() != 0)
            report_mismatch("missing beat", cipher_expected.pop_front(), 8'h00);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[filelist.f]
rtl/chacha_pkg.sv
rtl/chacha_dp.sv
rtl/chacha_ctrl.sv
rtl/chacha_stream_cipher_core.sv
tb/tb.sv
